// ===== hdl/pfb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types, constants and register codes of the page frame buffer blitter.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int MAX_COLUMNS  = 128;
  localparam int MAX_PAGES    = 8;
  localparam int IMAGE_BYTES  = 512;
  localparam int PIX_PER_BYTE = 8;

  localparam int FRAME_DEPTH = MAX_PAGES * MAX_COLUMNS;
  localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
  localparam int IMAGE_AW    = $clog2(IMAGE_BYTES);
  // byte offset within the image: column byte plus row times stride
  localparam int SPAN_W      = 15;
  localparam int PADDR_W     = 5;

  // item modes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_COMPOSE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // blend modes
  localparam logic [1:0] BLEND_OR        = 2'd0;
  localparam logic [1:0] BLEND_XOR       = 2'd1;
  localparam logic [1:0] BLEND_OVERWRITE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_IMAGE_STRIDE  = 3'd2;
  localparam logic [2:0] REG_X_OFFSET      = 3'd3;
  localparam logic [2:0] REG_Y_OFFSET      = 3'd4;
  localparam logic [2:0] REG_BLEND_MODE    = 3'd5;
  localparam logic [2:0] REG_DISPLAY_WIDTH = 3'd6;
  localparam logic [2:0] REG_DISPLAY_PAGES = 3'd7;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] image_addr;
    logic [7:0] image_data;
    logic [2:0] page_index;
    logic [6:0] column_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] image_width;
    logic [7:0] image_height;
    logic [5:0] image_stride;
    logic [8:0] x_offset;
    logic [8:0] y_offset;
    logic [1:0] blend_mode;
    logic [7:0] display_width;
    logic [3:0] display_pages;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:   8'd0,
    image_height:  8'd0,
    image_stride:  6'd0,
    x_offset:      9'd0,
    y_offset:      9'd0,
    blend_mode:    BLEND_OR,
    display_width: 8'd64,
    display_pages: 4'd6
  };

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MERGE
  } state_t;

  // image store write broadcast to every lane copy
  typedef struct packed {
    logic                we;
    logic [IMAGE_AW-1:0] addr;
    logic [7:0]          data;
  } img_wr_t;

endpackage
`default_nettype wire

// ===== hdl/pfb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/pfb_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_lane
// One pixel row of a frame byte: maps the display pixel into the image,
// clips it and fetches the image bit from a private copy of the image store.
// ----------------------------------------------------------------------------
module pfb_lane (
  input  wire logic                  clk,
  input  wire pfb_pkg::cfg_t         cfg,
  input  wire logic [2:0]            row,
  input  wire logic [2:0]            page_index,
  input  wire logic [6:0]            column_index,
  input  wire pfb_pkg::img_wr_t      img_wr,
  output logic                       pixel
);
  import pfb_pkg::*;

  logic signed [9:0]   ix;
  logic signed [9:0]   iy;
  logic [5:0]          cy;
  logic                in_image;
  logic [SPAN_W-1:0]   span;
  logic                in_store;
  logic [7:0]          rd_byte;
  logic                ok_r;
  logic [2:0]          bit_r;

  always_comb begin
    cy = {page_index, row};
    ix = $signed({3'b000, column_index}) - $signed({cfg.x_offset[8], cfg.x_offset});
    iy = $signed({4'b0000, cy}) - $signed({cfg.y_offset[8], cfg.y_offset});
    in_image = !ix[9] && !iy[9] &&
               (ix[8:0] < {1'b0, cfg.image_width}) &&
               (iy[8:0] < {1'b0, cfg.image_height});
    // ix and iy stay below 256 once inside the image
    span = SPAN_W'(ix[7:3]) + SPAN_W'(iy[7:0]) * SPAN_W'(cfg.image_stride);
    in_store = span < SPAN_W'(IMAGE_BYTES);
  end

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_img (
    .clk   (clk),
    .we    (img_wr.we),
    .waddr (img_wr.addr),
    .wdata (img_wr.data),
    .raddr (span[IMAGE_AW-1:0]),
    .rdata (rd_byte)
  );

  // track clip result alongside the registered read
  always_ff @(posedge clk) begin
    ok_r  <= in_image && in_store;
    bit_r <= ix[2:0];
  end

  assign pixel = ok_r & rd_byte[bit_r];

endmodule
`default_nettype wire

// ===== hdl/pfb_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_merge
// Combines the lane pixels with the stored frame byte by the blend mode.
// ----------------------------------------------------------------------------
module pfb_merge (
  input  wire logic [1:0] blend_mode,
  input  wire logic [7:0] old_byte,
  input  wire logic [7:0] pixels,
  output logic      [7:0] new_byte
);
  import pfb_pkg::*;

  always_comb begin
    case (blend_mode)
      BLEND_XOR:       new_byte = old_byte ^ pixels;
      BLEND_OVERWRITE: new_byte = pixels;
      default:         new_byte = old_byte | pixels;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/page_framebuffer_blit.sv =====
// Each accepted item is fetched, then merged; its result is registered at
// the end of the merge step, which waits until the output is free. A new
// item is taken only when idle or as the last one finishes; the frame store
// is read in fetch and written back in merge. Reset: synchronous, active
// low; a clearing pass then zeroes the frame store one byte a cycle with
// in_ready low; register writes are taken throughout.
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_blit
// Page-organized 1-bit frame buffer with an image blitter: eight row lanes
// fetch image bits in parallel and a merge stage blends them into the byte.
// ----------------------------------------------------------------------------
module page_framebuffer_blit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire pfb_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pfb_pkg::out_item_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import pfb_pkg::*;

  state_t              state_r, state_nxt;
  logic [FRAME_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  cfg_t                cfg_r;
  in_item_t            item_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_free;
  logic                in_xfer;
  logic                finish;
  logic                in_range;
  logic [FRAME_AW-1:0] fidx;
  logic [7:0]          frame_rd;
  logic [7:0]          pixels;
  logic [7:0]          new_byte;
  img_wr_t             img_wr;
  logic                frame_we;
  logic [FRAME_AW-1:0] frame_waddr;
  logic [7:0]          frame_wdata;
  logic                cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= pwdata[7:0];
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= pwdata[7:0];
        REG_IMAGE_STRIDE:  cfg_r.image_stride  <= pwdata[5:0];
        REG_X_OFFSET:      cfg_r.x_offset      <= pwdata[8:0];
        REG_Y_OFFSET:      cfg_r.y_offset      <= pwdata[8:0];
        REG_BLEND_MODE:    cfg_r.blend_mode    <= pwdata[1:0];
        REG_DISPLAY_WIDTH: cfg_r.display_width <= pwdata[7:0];
        REG_DISPLAY_PAGES: cfg_r.display_pages <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_IMAGE_WIDTH:   prdata = {24'd0, cfg_r.image_width};
      REG_IMAGE_HEIGHT:  prdata = {24'd0, cfg_r.image_height};
      REG_IMAGE_STRIDE:  prdata = {26'd0, cfg_r.image_stride};
      REG_X_OFFSET:      prdata = {23'd0, cfg_r.x_offset};
      REG_Y_OFFSET:      prdata = {23'd0, cfg_r.y_offset};
      REG_BLEND_MODE:    prdata = {30'd0, cfg_r.blend_mode};
      REG_DISPLAY_WIDTH: prdata = {24'd0, cfg_r.display_width};
      REG_DISPLAY_PAGES: prdata = {28'd0, cfg_r.display_pages};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------- control ----------------
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == ST_MERGE) && out_free;
  assign in_ready = (state_r == ST_IDLE) || finish;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == FRAME_AW'(FRAME_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (out_free) begin
          state_nxt = in_valid ? ST_FETCH : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (finish) begin
      out_r <= out_nxt;
    end
  end

  // ---------------- datapath ----------------
  assign in_range = ({1'b0, item_r.page_index} < cfg_r.display_pages) &&
                    ({1'b0, item_r.page_index} < 4'(MAX_PAGES)) &&
                    ({1'b0, item_r.column_index} < cfg_r.display_width) &&
                    ({1'b0, item_r.column_index} < 8'(MAX_COLUMNS));

  assign fidx = FRAME_AW'(item_r.page_index) * FRAME_AW'(MAX_COLUMNS) +
                FRAME_AW'(item_r.column_index);

  always_comb begin
    img_wr.we   = (state_r == ST_FETCH) && (item_r.mode == MODE_LOAD) &&
                  ({1'b0, item_r.image_addr} < 10'(IMAGE_BYTES));
    img_wr.addr = IMAGE_AW'(item_r.image_addr);
    img_wr.data = item_r.image_data;
  end

  for (genvar r = 0; r < PIX_PER_BYTE; r++) begin : g_lane
    pfb_lane u_lane (
      .clk          (clk),
      .cfg          (cfg_r),
      .row          (3'(r)),
      .page_index   (item_r.page_index),
      .column_index (item_r.column_index),
      .img_wr       (img_wr),
      .pixel        (pixels[r])
    );
  end

  pfb_merge u_merge (
    .blend_mode (cfg_r.blend_mode),
    .old_byte   (frame_rd),
    .pixels     (pixels),
    .new_byte   (new_byte)
  );

  // clearing pass owns the write port until it is done
  always_comb begin
    if (state_r == ST_CLEAR) begin
      frame_we    = 1'b1;
      frame_waddr = clr_cnt_r;
      frame_wdata = 8'd0;
    end else begin
      frame_we    = finish && (item_r.mode == MODE_COMPOSE) && in_range;
      frame_waddr = fidx;
      frame_wdata = new_byte;
    end
  end

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (fidx),
    .rdata (frame_rd)
  );

  always_comb begin
    out_nxt = '0;
    case (item_r.mode)
      MODE_COMPOSE: begin
        if (in_range) begin
          out_nxt.frame_byte = new_byte;
        end else begin
          out_nxt.status = 1'b1;
        end
      end
      MODE_READ: begin
        if (in_range) begin
          out_nxt.frame_byte = frame_rd;
        end else begin
          out_nxt.status = 1'b1;
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("item accepted during frame clearing pass");

  a_accept_starts_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_FETCH)
    else $error("accepted item did not start a fetch");

  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MERGE))
    else $error("result raised outside the merge step");

  a_frame_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    frame_we && state_r != ST_CLEAR |-> finish && item_r.mode == MODE_COMPOSE)
    else $error("frame store written outside a compose");
`endif

endmodule
`default_nettype wire

// ===== tb/page_framebuffer_blit_tb.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_blit_tb
// Drives image loads, frame composes and frame reads into the blitter under a
// series of register settings and stall patterns, and checks every returned
// frame byte and status against pinned answers or a local image/frame copy.
// ----------------------------------------------------------------------------
module page_framebuffer_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;

  localparam logic [1:0] MODE_IDLE_CODE = 2'd3;  // ignored by the block
  localparam logic [1:0] BLEND_ALT      = 2'd3;  // acts as overlay
  localparam int SETUP_ROW   = 9;
  localparam int NUM_ROWS    = 23;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 94;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic      pready;

  // item in flight on the input channel and its hand-typed answer, if any
  logic      pin_en;
  out_item_t pin_val;

  cfg_t      cur;
  logic [7:0] frame_mem [FRAME_DEPTH];
  logic [7:0] image_mem [IMAGE_BYTES];
  bit        gen_loaded [IMAGE_BYTES];
  out_item_t frame_results_due [$];
  dir_row_t  dir_rows [NUM_ROWS];
  int        errors = 0;
  int        quiet = 0;
  int        send_idle = 0;
  int        recv_stall = 0;

  page_framebuffer_blit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit off_panel(logic [2:0] page, logic [6:0] col);
    return (page >= cur.display_pages) || (col >= cur.display_width);
  endfunction

  // image byte feeding row rr of a frame byte, or -1 if the pixel is clipped
  function automatic int source_addr(logic [2:0] page, logic [6:0] col, int rr,
                                     output int bitpos);
    int ix, iy, a;
    ix = int'(col) - int'($signed(cur.x_offset));
    iy = int'(page) * PIX_PER_BYTE + rr - int'($signed(cur.y_offset));
    bitpos = 0;
    if (ix < 0 || iy < 0 || ix >= int'(cur.image_width) || iy >= int'(cur.image_height))
      return -1;
    a = ix / PIX_PER_BYTE + iy * int'(cur.image_stride);
    bitpos = ix % PIX_PER_BYTE;
    return (a < IMAGE_BYTES) ? a : -1;
  endfunction

  function automatic out_item_t predict_frame_byte(in_item_t it);
    out_item_t res;
    logic [7:0] b;
    int fidx, a, bp;
    res = '0;
    case (it.mode)
      MODE_LOAD: image_mem[it.image_addr] = it.image_data;
      MODE_COMPOSE, MODE_READ: begin
        if (off_panel(it.page_index, it.column_index)) begin
          res.status = 1'b1;
        end else begin
          fidx = int'(it.page_index) * MAX_COLUMNS + int'(it.column_index);
          b = frame_mem[fidx];
          if (it.mode == MODE_COMPOSE) begin
            for (int rr = 0; rr < PIX_PER_BYTE; rr++) begin
              a = source_addr(it.page_index, it.column_index, rr, bp);
              if (a >= 0 && image_mem[a][bp]) begin
                if (cur.blend_mode == BLEND_XOR) b[rr] = ~b[rr];
                else b[rr] = 1'b1;
              end else if (cur.blend_mode == BLEND_OVERWRITE) begin
                b[rr] = 1'b0;
              end
            end
            frame_mem[fidx] = b;
          end
          res.frame_byte = b;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // a compose may only touch image bytes already sent as loads
  function automatic bit image_covered(logic [2:0] page, logic [6:0] col,
                                       output int miss);
    int a, bp;
    miss = 0;
    if (off_panel(page, col)) return 1'b1;
    for (int rr = 0; rr < PIX_PER_BYTE; rr++) begin
      a = source_addr(page, col, rr, bp);
      if (a >= 0 && !gen_loaded[a]) begin
        miss = a;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t mk(logic [1:0] m, int addr, int data, int pg, int cl,
                                  bit pinned, int fb, bit st);
    dir_row_t d;
    d.item.mode         = m;
    d.item.image_addr   = addr[8:0];
    d.item.image_data   = data[7:0];
    d.item.page_index   = pg[2:0];
    d.item.column_index = cl[6:0];
    d.pinned            = pinned;
    d.want.frame_byte   = fb[7:0];
    d.want.status       = st;
    return d;
  endfunction

  function automatic cfg_t phase_setup(int k);
    cfg_t c;
    c.image_width   = 8'($urandom_range(64, 1));
    c.image_height  = 8'($urandom_range(64, 1));
    c.image_stride  = ($urandom_range(3) == 0) ? 6'($urandom_range(32))
                    : 6'((int'(c.image_width) + 7) / 8 + $urandom_range(2));
    c.x_offset      = 9'($urandom_range(40) - 16);
    c.y_offset      = 9'($urandom_range(40) - 16);
    c.blend_mode    = (k == 3) ? BLEND_ALT : 2'($urandom_range(2));
    c.display_width = ($urandom_range(1) == 0) ? 8'd128 : 8'($urandom_range(128, 1));
    c.display_pages = 4'($urandom_range(8, 1));
    case (k)
      0: c = '{image_width: 8'd255, image_height: 8'd255, image_stride: 6'd32,
               x_offset: 9'd0, y_offset: 9'd0, blend_mode: BLEND_OVERWRITE,
               display_width: 8'd128, display_pages: 4'd8};
      1: c = '{image_width: 8'd0, image_height: 8'd0, image_stride: 6'd0,
               x_offset: 9'h100, y_offset: 9'h0ff, blend_mode: BLEND_XOR,
               display_width: 8'd1, display_pages: 4'd1};
      2: c = '{image_width: 8'd255, image_height: 8'd255, image_stride: 6'd1,
               x_offset: 9'h0ff, y_offset: 9'h100, blend_mode: BLEND_OR,
               display_width: 8'd128, display_pages: 4'd8};
      default: ;
    endcase
    return c;
  endfunction

  function automatic in_item_t draw_item();
    in_item_t it;
    int roll, ix, iy, a, cy, cx;
    it = in_item_t'($urandom);
    roll = $urandom_range(99);
    if (roll < 45) it.mode = MODE_COMPOSE;
    else if (roll < 70) it.mode = MODE_LOAD;
    else if (roll < 95) it.mode = MODE_READ;
    else it.mode = MODE_IDLE_CODE;
    if (it.mode == MODE_LOAD && $urandom_range(3) != 0 && cur.image_width != 0 &&
        cur.image_height != 0) begin
      ix = $urandom_range(int'(cur.image_width) - 1);
      iy = $urandom_range(int'(cur.image_height) - 1);
      a = ix / PIX_PER_BYTE + iy * int'(cur.image_stride);
      if (a < IMAGE_BYTES) it.image_addr = 9'(a);
    end
    if ((it.mode == MODE_COMPOSE || it.mode == MODE_READ) && $urandom_range(9) != 0) begin
      it.page_index   = 3'($urandom_range(int'(cur.display_pages) - 1));
      it.column_index = 7'($urandom_range(int'(cur.display_width) - 1));
      // aim most composes at the image footprint
      if (it.mode == MODE_COMPOSE && $urandom_range(9) < 6) begin
        cx = int'($signed(cur.x_offset)) + $urandom_range(int'(cur.image_width) + 7);
        cy = int'($signed(cur.y_offset)) + $urandom_range(int'(cur.image_height) + 7);
        if (cx >= 0 && cx < int'(cur.display_width)) it.column_index = 7'(cx);
        if (cy >= 0 && cy / PIX_PER_BYTE < int'(cur.display_pages))
          it.page_index = 3'(cy / PIX_PER_BYTE);
      end
    end
    return it;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setup(cfg_t c);
    reg_write(REG_IMAGE_WIDTH,   32'(c.image_width));
    reg_write(REG_IMAGE_HEIGHT,  32'(c.image_height));
    reg_write(REG_IMAGE_STRIDE,  32'(c.image_stride));
    reg_write(REG_X_OFFSET,      32'(c.x_offset));
    reg_write(REG_Y_OFFSET,      32'(c.y_offset));
    reg_write(REG_BLEND_MODE,    32'(c.blend_mode));
    reg_write(REG_DISPLAY_WIDTH, 32'(c.display_width));
    reg_write(REG_DISPLAY_PAGES, 32'(c.display_pages));
    cur = c;
  endtask

  task automatic send(in_item_t it, bit pin, out_item_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    pin_en   <= pin;
    pin_val  <= want;
    if (it.mode == MODE_LOAD) gen_loaded[it.image_addr] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  // score results, then predict the item taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          $error("result with nothing outstanding: frame_byte %0h status %0b",
                 out_data.frame_byte, out_data.status);
          errors++;
        end else begin
          want = frame_results_due.pop_front();
          if (out_data.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, out_data.frame_byte);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_data.status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = predict_frame_byte(in_data);
        if (pin_en) want = pin_val;
        frame_results_due.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    cfg_t dir_setup;
    in_item_t it;
    int miss;
    in_valid = 1'b0;
    in_data  = '0;
    pin_en   = 1'b0;
    pin_val  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    cur      = CFG_RESET;
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    foreach (image_mem[i]) image_mem[i] = 8'h00;
    foreach (gen_loaded[i]) gen_loaded[i] = 1'b0;

    // reset settings: 64 columns, 6 pages, empty image
    dir_rows[0]  = mk(MODE_READ,      0,     0,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[1]  = mk(MODE_READ,      0,     0,   5,  63, 1, 8'h00, 1'b0);
    dir_rows[2]  = mk(MODE_READ,      0,     0,   6,   0, 1, 8'h00, 1'b1);
    dir_rows[3]  = mk(MODE_READ,      0,     0,   0,  64, 1, 8'h00, 1'b1);
    dir_rows[4]  = mk(MODE_COMPOSE,   0,     0,   7, 127, 1, 8'h00, 1'b1);
    dir_rows[5]  = mk(MODE_COMPOSE,   0,     0,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[6]  = mk(MODE_IDLE_CODE, 511, 255,   7, 127, 1, 8'h00, 1'b0);
    dir_rows[7]  = mk(MODE_LOAD,      511, 255,   7, 127, 1, 8'h00, 1'b0);
    dir_rows[8]  = mk(MODE_LOAD,      0,     0,   0,   0, 1, 8'h00, 1'b0);
    // 8x8 image, stride 1, full panel: draw an X
    dir_rows[9]  = mk(MODE_LOAD,      0, 8'h81,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[10] = mk(MODE_LOAD,      1, 8'h42,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[11] = mk(MODE_LOAD,      2, 8'h24,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[12] = mk(MODE_LOAD,      3, 8'h18,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[13] = mk(MODE_LOAD,      4, 8'h18,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[14] = mk(MODE_LOAD,      5, 8'h24,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[15] = mk(MODE_LOAD,      6, 8'h42,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[16] = mk(MODE_LOAD,      7, 8'h81,   0,   0, 1, 8'h00, 1'b0);
    dir_rows[17] = mk(MODE_COMPOSE,   0,     0,   0,   0, 0, 0, 1'b0);
    dir_rows[18] = mk(MODE_COMPOSE,   0,     0,   0,   7, 0, 0, 1'b0);
    dir_rows[19] = mk(MODE_COMPOSE,   0,     0,   0,   8, 0, 0, 1'b0);
    dir_rows[20] = mk(MODE_COMPOSE,   0,     0,   7, 127, 0, 0, 1'b0);
    dir_rows[21] = mk(MODE_READ,      0,     0,   0,   0, 0, 0, 1'b0);
    dir_rows[22] = mk(MODE_COMPOSE,   0,     0,   1,   3, 0, 0, 1'b0);
    dir_setup = '{image_width: 8'd8, image_height: 8'd8, image_stride: 6'd1,
                  x_offset: 9'd0, y_offset: 9'd0, blend_mode: BLEND_OR,
                  display_width: 8'd128, display_pages: 4'd8};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == SETUP_ROW) begin
        drain();
        apply_setup(dir_setup);
      end
      send(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_setup(phase_setup(p));
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = draw_item();
        // fill the image bytes a compose needs before sending it
        if (it.mode == MODE_COMPOSE && !image_covered(it.page_index, it.column_index, miss))
        begin
          it.mode       = MODE_LOAD;
          it.image_addr = 9'(miss);
        end
        send(it, 1'b0, '0);
      end
    end

    send_idle  = 0;
    recv_stall = 0;
    drain();
    repeat (4) @(posedge clk);
    if (errors == 0 && frame_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pfb_pkg.sv
hdl/pfb_ram.sv
hdl/pfb_lane.sv
hdl/pfb_merge.sv
hdl/page_framebuffer_blit.sv
tb/page_framebuffer_blit_tb.sv
